/* sv/e2q_pkg.sv */
// e2q_pkg: shared constants and the cordic arctangent table for euler_to_quaternion
// no dependencies
package e2q_pkg;
    localparam int CORDIC_STEPS = 32;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic signed [33:0] atan_step(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0: a = 32'h20000000;  5'd1: a = 32'h12E4051E;
            5'd2: a = 32'h09FB385B;  5'd3: a = 32'h051111D4;
            5'd4: a = 32'h028B0D43;  5'd5: a = 32'h0145D7E1;
            5'd6: a = 32'h00A2F61E;  5'd7: a = 32'h00517C55;
            5'd8: a = 32'h0028BE53;  5'd9: a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA; 5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30; 5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C; 5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3; 5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029; 5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A; 5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003; 5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return $signed({1'b0, a, 1'b0});
    endfunction
endpackage

/* sv/e2q_if.sv */
// e2q_angle_if and e2q_quat_if: valid/ready channels for angle and quaternion words
// no dependencies
interface e2q_angle_if #(parameter int ANGLE_BITS = 16) (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if #(parameter int COMPONENT_BITS = 16) (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
    logic signed [COMPONENT_BITS-1:0] quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

/* sv/e2q_cordic_stage.sv */
// e2q_cordic_stage: one registered micro-rotation for three angles in parallel
// depends on e2q_pkg
module e2q_cordic_stage
    import e2q_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  logic signed [33:0] i_x [3],
    input  logic signed [33:0] i_y [3],
    input  logic signed [34:0] i_z [3],
    output logic signed [33:0] o_x [3],
    output logic signed [33:0] o_y [3],
    output logic signed [34:0] o_z [3]
);
    logic signed [33:0] r_x [3];
    logic signed [33:0] r_y [3];
    logic signed [34:0] r_z [3];
    logic signed [33:0] n_x [3];
    logic signed [33:0] n_y [3];
    logic signed [34:0] n_z [3];
    logic signed [34:0] w_a;

    always_comb begin
        w_a = 35'(atan_step(5'(STEP)));
        for (int k = 0; k < 3; k++) begin
            if (!i_z[k][34]) begin
                n_x[k] = i_x[k] - (i_y[k] >>> STEP);
                n_y[k] = i_y[k] + (i_x[k] >>> STEP);
                n_z[k] = i_z[k] - w_a;
            end else begin
                n_x[k] = i_x[k] + (i_y[k] >>> STEP);
                n_y[k] = i_y[k] - (i_x[k] >>> STEP);
                n_z[k] = i_z[k] + w_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

/* sv/e2q_product.sv */
// e2q_product: triple products, sums, rounding and saturation over four stages
// depends on e2q_pkg
module e2q_product
    import e2q_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_en,
    input  logic signed [33:0] i_c [3],
    input  logic signed [33:0] i_s [3],
    output logic signed [COMPONENT_BITS-1:0] o_q [4]
);
    localparam int SH = 61 - COMPONENT_BITS;
    localparam logic signed [67:0] HI = 68'sd1 <<< (COMPONENT_BITS - 1);

    logic signed [33:0] r_cy, r_sy;
    logic signed [33:0] r_ab [4];
    logic signed [67:0] r_t [8];
    logic signed [68:0] r_sum [4];
    logic signed [COMPONENT_BITS-1:0] r_q [4];
    logic signed [67:0] n_ab [4];
    logic signed [68:0] w_r [4];

    always_comb begin
        n_ab[0] = i_s[0] * i_c[1];
        n_ab[1] = i_c[0] * i_s[1];
        n_ab[2] = i_c[0] * i_c[1];
        n_ab[3] = i_s[0] * i_s[1];
        for (int k = 0; k < 4; k++) begin
            w_r[k] = (r_sum[k] + (69'sd1 <<< (SH - 1))) >>> SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cy <= i_c[2];
            r_sy <= i_s[2];
            for (int k = 0; k < 4; k++) begin
                r_ab[k] <= 34'((n_ab[k] + 68'sd536870912) >>> 30);
            end
            r_t[0] <= r_ab[0] * r_cy;
            r_t[1] <= r_ab[1] * r_sy;
            r_t[2] <= r_ab[1] * r_cy;
            r_t[3] <= r_ab[0] * r_sy;
            r_t[4] <= r_ab[2] * r_sy;
            r_t[5] <= r_ab[3] * r_cy;
            r_t[6] <= r_ab[2] * r_cy;
            r_t[7] <= r_ab[3] * r_sy;
            r_sum[0] <= 69'(r_t[0]) - 69'(r_t[1]);
            r_sum[1] <= 69'(r_t[2]) + 69'(r_t[3]);
            r_sum[2] <= 69'(r_t[4]) - 69'(r_t[5]);
            r_sum[3] <= 69'(r_t[6]) + 69'(r_t[7]);
            for (int k = 0; k < 4; k++) begin
                if (w_r[k] >= 69'(HI)) r_q[k] <= {1'b0, {(COMPONENT_BITS-1){1'b1}}};
                else if (w_r[k] < -69'(HI)) r_q[k] <= {1'b1, {(COMPONENT_BITS-1){1'b0}}};
                else r_q[k] <= w_r[k][COMPONENT_BITS-1:0];
            end
        end
    end

    assign o_q = r_q;
endmodule

/* sv/euler_to_quaternion.sv */
// euler_to_quaternion: roll, pitch and yaw binary angles to a unit quaternion in Q1.15
// depends on e2q_pkg, e2q_if, e2q_cordic_stage, e2q_product
// input channel carries roll, pitch, yaw; output channel carries x, y, z, w.
// a word is taken at each edge with valid and ready high on a channel.
// three 32-step cordic chains run in lockstep, one micro-rotation per stage,
// followed by four product stages, the last of which holds the output register.
// one word enters every cycle when the receiver takes words every cycle.
// the whole pipeline advances as one; when the receiver stalls with a word
// waiting, the pipeline freezes and input ready drops, so nothing is lost.
// reset clears all valid bits; payload registers are not reset.
// latency set by the cordic chain length and the four product stages.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int COMPONENT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    e2q_angle_if.sink i_angle,
    e2q_quat_if.source o_quat
);
    localparam int DEPTH = CORDIC_STEPS + 4;

    logic [DEPTH-1:0] r_vld;
    logic w_en;
    logic signed [33:0] w_x [CORDIC_STEPS+1][3];
    logic signed [33:0] w_y [CORDIC_STEPS+1][3];
    logic signed [34:0] w_z [CORDIC_STEPS+1][3];
    logic signed [COMPONENT_BITS-1:0] w_q [4];

    assign w_en = !r_vld[DEPTH-1] || o_quat.ready;
    assign i_angle.ready = w_en;

    for (genvar k = 0; k < 3; k++) begin : g_seed
        assign w_x[0][k] = CORDIC_GAIN;
        assign w_y[0][k] = '0;
    end
    assign w_z[0][0] = 35'(i_angle.roll_angle) <<< (32 - ANGLE_BITS);
    assign w_z[0][1] = 35'(i_angle.pitch_angle) <<< (32 - ANGLE_BITS);
    assign w_z[0][2] = 35'(i_angle.yaw_angle) <<< (32 - ANGLE_BITS);

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        e2q_cordic_stage #(.STEP(g)) u_stage (
            .i_clk(i_clk), .i_en(w_en),
            .i_x(w_x[g]), .i_y(w_y[g]), .i_z(w_z[g]),
            .o_x(w_x[g+1]), .o_y(w_y[g+1]), .o_z(w_z[g+1])
        );
    end

    e2q_product #(.COMPONENT_BITS(COMPONENT_BITS)) u_prod (
        .i_clk(i_clk), .i_en(w_en),
        .i_c(w_x[CORDIC_STEPS]), .i_s(w_y[CORDIC_STEPS]), .o_q(w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_angle.valid};
        end
    end

    assign o_quat.valid = r_vld[DEPTH-1];
    assign o_quat.quat_x = w_q[0];
    assign o_quat.quat_y = w_q[1];
    assign o_quat.quat_z = w_q[2];
    assign o_quat.quat_w = w_q[3];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid && !o_quat.ready |=> o_quat.valid && $stable(o_quat.quat_w))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_quat.valid |-> i_angle.ready)
        else $error("input blocked while output empty");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_angle.ready |=> $stable(r_vld))
        else $error("pipeline moved while frozen");
endmodule

/* sim/testbench.sv */
// testbench for euler_to_quaternion: drives angle words, checks quaternion words
// against a bit-true cordic and product predictor; depends on e2q_pkg, e2q_if, euler_to_quaternion
module testbench;
    import e2q_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } t_quat;

    typedef struct {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        bit          known;
        t_quat       q;
    } t_angle_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    e2q_angle_if #(.ANGLE_BITS(16)) angle_ch (.i_clk(i_clk));
    e2q_quat_if #(.COMPONENT_BITS(16)) quat_ch (.i_clk(i_clk));

    euler_to_quaternion #(.ANGLE_BITS(16), .COMPONENT_BITS(16)) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_angle(angle_ch.sink),
        .o_quat(quat_ch.source)
    );

    t_quat expected_quats[$];
    int    fail_count = 0;
    int    send_idle_pct = 7;
    int    recv_idle_pct = 51;
    int    hold_off_cycles = 0;
    bit    sending_done = 1'b0;
    t_angle_row rows[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void half_cos_sin(logic [15:0] ang, output longint c,
                                         output longint s);
        longint xc, yc, zc, dx, dy, a;
        xc = 652032874;
        yc = 0;
        zc = longint'($signed(ang)) * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shr(yc, i);
            dy = floor_shr(xc, i);
            a = longint'(atan_step(5'(i)));
            if (zc >= 0) begin
                xc -= dx; yc += dy; zc -= a;
            end else begin
                xc += dx; yc -= dy; zc += a;
            end
        end
        c = xc;
        s = yc;
    endfunction

    function automatic longint triple(longint a, longint b, longint c);
        return floor_shr(a * b + (64'sd1 <<< 29), 30) * c;
    endfunction

    function automatic logic signed [15:0] to_q15(longint sum);
        longint r;
        r = floor_shr(sum + (64'sd1 <<< 44), 45);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic t_quat euler_quat(logic [15:0] r, logic [15:0] p, logic [15:0] y);
        longint cr, sr, cp, sp, cy, sy;
        t_quat q;
        half_cos_sin(r, cr, sr);
        half_cos_sin(p, cp, sp);
        half_cos_sin(y, cy, sy);
        q.x = to_q15(triple(sr, cp, cy) - triple(cr, sp, sy));
        q.y = to_q15(triple(cr, sp, cy) + triple(sr, cp, sy));
        q.z = to_q15(triple(cr, cp, sy) - triple(sr, sp, cy));
        q.w = to_q15(triple(cr, cp, cy) + triple(sr, sp, sy));
        return q;
    endfunction

    task automatic add_row(logic [15:0] r, logic [15:0] p, logic [15:0] y,
                           bit known = 0, t_quat q = '0);
        t_angle_row row;
        row.roll = r; row.pitch = p; row.yaw = y; row.known = known; row.q = q;
        rows.push_back(row);
    endtask

    task automatic send_word(t_angle_row row);
        t_quat q;
        while ($urandom_range(99) < send_idle_pct) begin
            angle_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        q = euler_quat(row.roll, row.pitch, row.yaw);
        if (row.known && q !== row.q) begin
            $display("%0t table row mismatch: expected %h actual %h", $time, row.q, q);
            fail_count++;
        end
        angle_ch.valid <= 1'b1;
        angle_ch.roll_angle <= row.roll;
        angle_ch.pitch_angle <= row.pitch;
        angle_ch.yaw_angle <= row.yaw;
        @(posedge i_clk);
        while (!angle_ch.ready) @(posedge i_clk);
        expected_quats.push_back(q);
        @(negedge i_clk);
    endtask

    task automatic send_random(int n);
        t_angle_row row;
        for (int k = 0; k < n; k++) begin
            row.known = 0;
            case ($urandom_range(3))
                0: begin
                    row.roll = 16'($urandom_range(65535));
                    row.pitch = 16'($urandom_range(65535));
                    row.yaw = 16'($urandom_range(65535));
                end
                1: begin
                    row.roll = {$urandom_range(1) ? 16'h8000 : 16'h7fff};
                    row.pitch = 16'($urandom_range(65535));
                    row.yaw = {$urandom_range(1) ? 16'h8000 : 16'h0000};
                end
                default: begin
                    row.roll = 16'($signed(10'($urandom_range(1023))));
                    row.pitch = 16'($urandom_range(65535)) ^ 16'h8000;
                    row.yaw = 16'($signed(10'($urandom_range(1023))));
                end
            endcase
            send_word(row);
        end
    endtask

    initial begin
        angle_ch.valid = 1'b0;
        angle_ch.roll_angle = '0;
        angle_ch.pitch_angle = '0;
        angle_ch.yaw_angle = '0;
        // extremes, zero, quarter turns and mixed patterns
        add_row(16'h0000, 16'h0000, 16'h0000, 1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
        add_row(16'h8000, 16'h0000, 16'h0000, 1, '{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
        add_row(16'h0000, 16'h8000, 16'h0000);
        add_row(16'h0000, 16'h0000, 16'h8000);
        add_row(16'h7fff, 16'h7fff, 16'h7fff);
        add_row(16'h8000, 16'h8000, 16'h8000);
        add_row(16'h4000, 16'h0000, 16'h0000);
        add_row(16'h0000, 16'hc000, 16'h0000);
        add_row(16'h0000, 16'h0000, 16'h4000);
        add_row(16'h0001, 16'hffff, 16'h0001);
        add_row(16'h5555, 16'haaaa, 16'h5555);
        add_row(16'haaaa, 16'h5555, 16'haaaa);
        add_row(16'hffff, 16'hffff, 16'hffff);
        add_row(16'h2000, 16'h2000, 16'h2000);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[i]) send_word(rows[i]);
        send_random(250);
        // long receiver hold-off while words keep coming
        hold_off_cycles = 300;
        send_random(80);
        angle_ch.valid <= 1'b0;
        while (expected_quats.size() != 0) @(negedge i_clk);
        send_idle_pct = 51;
        recv_idle_pct = 7;
        send_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(250);
        angle_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        quat_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                quat_ch.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                quat_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            got = '{quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z, quat_ch.quat_w};
            if (expected_quats.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                fail_count++;
            end else begin
                want = expected_quats.pop_front();
                if (got.x !== want.x) begin
                    $display("%0t quat_x: expected %0d actual %0d", $time, want.x, got.x);
                    fail_count++;
                end
                if (got.y !== want.y) begin
                    $display("%0t quat_y: expected %0d actual %0d", $time, want.y, got.y);
                    fail_count++;
                end
                if (got.z !== want.z) begin
                    $display("%0t quat_z: expected %0d actual %0d", $time, want.z, got.z);
                    fail_count++;
                end
                if (got.w !== want.w) begin
                    $display("%0t quat_w: expected %0d actual %0d", $time, want.w, got.w);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int waited;
        waited = 0;
        wait (sending_done);
        while (expected_quats.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (80) @(posedge i_clk);
        if (expected_quats.size() != 0) begin
            $display("%0t %0d words never arrived", $time, expected_quats.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS euler_to_quaternion");
        end else begin
            $display("FAIL euler_to_quaternion");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL euler_to_quaternion");
        $finish;
    end
endmodule

/* filelist.f */
sv/e2q_pkg.sv
sv/e2q_if.sv
sv/e2q_cordic_stage.sv
sv/e2q_product.sv
sv/euler_to_quaternion.sv
sim/testbench.sv
